// ===== design/tmtw_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmtw_pkg
// Types, constants and the control program of the text-mode terminal writer.
// ============================================================================
package tmtw_pkg;

    // Screen geometry and field widths
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = COLOR_W + CHAR_W;
    localparam int STEP_W  = 4;

    localparam int S_FIELDS_W = CHAR_W + ADDR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ROW_W + COL_W + CELL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [ADDR_W-1:0] COLUMNS_A = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] CELLS_A   = ADDR_W'(CELLS);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COL_LIMIT = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0]    TAB_STEP  = (COL_W + 1)'(8);
    localparam logic [COL_W:0]    TAB_MASK  = (COL_W + 1)'(8 - 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [COLOR_W-1:0] COLOR_LIGHT_GRAY = 8'h07;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT,
        KIND_CLEAR,
        KIND_READ
    } kind_t;

    // Steps of the control program
    typedef enum logic [STEP_W-1:0] {
        S_IDLE,
        S_PUT,
        S_NEWLINE,
        S_ROW_INC,
        S_RETURN,
        S_BKSP,
        S_TAB,
        S_TAB_WRAP,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_EMIT
    } step_t;

    typedef enum logic [2:0] {
        COL_HOLD,
        COL_ZERO,
        COL_INC,
        COL_DEC,
        COL_TAB
    } col_op_t;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_ZERO,
        ROW_INC
    } row_op_t;

    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_INC
    } addr_op_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_READ,
        MEM_COPY,
        MEM_BLANK
    } mem_op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_GOTO,
        C_ACCEPT,
        C_PUT_OK,
        C_ROW_LAST,
        C_TAB_OK,
        C_COPY_LOOP,
        C_FILL_LOOP,
        C_EMIT
    } cond_t;

    typedef struct packed {
        col_op_t  col_op;
        row_op_t  row_op;
        addr_op_t addr_op;
        mem_op_t  mem_op;
        logic     emit;
        cond_t    cond;
        step_t    target;
    } ucode_t;

    function automatic ucode_t uword(col_op_t c, row_op_t r, addr_op_t a, mem_op_t m,
                                     logic e, cond_t cd, step_t t);
        ucode_t w;
        w.col_op  = c;
        w.row_op  = r;
        w.addr_op = a;
        w.mem_op  = m;
        w.emit    = e;
        w.cond    = cd;
        w.target  = t;
        return w;
    endfunction

    // Control store: one word per step.
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        case (s)
            S_IDLE:     w = uword(COL_HOLD, ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_ACCEPT, S_IDLE);
            S_PUT:      w = uword(COL_INC,  ROW_HOLD, ADDR_HOLD, MEM_PUT,   1'b0, C_PUT_OK, S_EMIT);
            S_NEWLINE:  w = uword(COL_ZERO, ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_ROW_LAST,
                                  S_SCROLL);
            S_ROW_INC:  w = uword(COL_HOLD, ROW_INC,  ADDR_HOLD, MEM_NONE,  1'b0, C_GOTO, S_EMIT);
            S_RETURN:   w = uword(COL_ZERO, ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_GOTO, S_EMIT);
            S_BKSP:     w = uword(COL_DEC,  ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_GOTO, S_EMIT);
            S_TAB:      w = uword(COL_TAB,  ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_TAB_OK, S_EMIT);
            S_TAB_WRAP: w = uword(COL_HOLD, ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_GOTO,
                                  S_NEWLINE);
            S_READ:     w = uword(COL_HOLD, ROW_HOLD, ADDR_HOLD, MEM_READ,  1'b0, C_GOTO, S_EMIT);
            S_CLEAR:    w = uword(COL_ZERO, ROW_ZERO, ADDR_ZERO, MEM_NONE,  1'b0, C_GOTO, S_FILL);
            S_SCROLL:   w = uword(COL_HOLD, ROW_HOLD, ADDR_ZERO, MEM_NONE,  1'b0, C_NEXT, S_IDLE);
            S_COPY:     w = uword(COL_HOLD, ROW_HOLD, ADDR_INC,  MEM_COPY,  1'b0, C_COPY_LOOP,
                                  S_IDLE);
            S_DRAIN:    w = uword(COL_HOLD, ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_NEXT, S_IDLE);
            S_FILL:     w = uword(COL_HOLD, ROW_HOLD, ADDR_INC,  MEM_BLANK, 1'b0, C_FILL_LOOP,
                                  S_IDLE);
            S_EMIT:     w = uword(COL_HOLD, ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b1, C_EMIT, S_IDLE);
            default:    w = uword(COL_HOLD, ROW_HOLD, ADDR_HOLD, MEM_NONE,  1'b0, C_GOTO, S_IDLE);
        endcase
        return w;
    endfunction

    // First step for a request, from its kind and character.
    function automatic step_t dispatch(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] code);
        step_t s;
        case (kind)
            KIND_PUT:
            begin
                if (code == CH_NEWLINE) begin
                    s = S_NEWLINE;
                end else if (code == CH_RETURN) begin
                    s = S_RETURN;
                end else if (code == CH_BACKSPACE) begin
                    s = S_BKSP;
                end else if (code == CH_TAB) begin
                    s = S_TAB;
                end else if (code >= CH_SPACE) begin
                    s = S_PUT;
                end else begin
                    s = S_EMIT;
                end
            end
            KIND_CLEAR: s = S_CLEAR;
            KIND_READ:  s = S_READ;
            default:    s = S_EMIT;
        endcase
        return s;
    endfunction

endpackage

// ===== design/tmtw_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmtw_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/text_mode_terminal_writer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// text_mode_terminal_writer
// Text-cell store with cursor, driven by a small microcoded sequencer.
// ============================================================================
// Requests arrive on the s_ channel: tuser carries the kind (put, clear,
// read), tdata the character and the cell index. Every request gives one
// result on the m_ channel with the cursor after the request and, for a
// read, the cell. The cfg_ channel writes the attribute byte; it is always
// ready and should be used only while no request is in flight.
// One request is worked at a time. The sequencer steps through its control
// store one word a cycle while it does not hold in its emit step. A
// character written in the last column and a tab that runs past the right
// edge go on through the newline steps. A scroll walks the cell RAM
// through its single write port, one cell a cycle: about COLUMNS*(ROWS-1)
// copies plus COLUMNS blanks. A clear fills all ROWS*COLUMNS cells.
// The result register decouples the output: a new request is accepted while
// a result still waits, and the sequencer holds in its emit step if the
// receiver stalls. Reset homes the cursor and sets the attribute to light
// gray; the cell contents are undefined until the first clear.
module text_mode_terminal_writer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tmtw_pkg::S_TDATA_W-1:0] s_tdata,   // char_code, read_index, zero pad
    input  logic [tmtw_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tmtw_pkg::M_TDATA_W-1:0] m_tdata,   // cursor_row, cursor_col, cell_value, pad
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmtw_pkg::COLOR_W-1:0]   cfg_data
);
    import tmtw_pkg::*;

    step_t              pc_reg, pc_next, pc_inc;
    ucode_t             uc;

    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [ADDR_W-1:0]  index_reg, index_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               copy_wr_reg, copy_wr_next;
    logic [ADDR_W-1:0]  copy_addr_reg, copy_addr_next;

    logic               out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [CELL_W-1:0]  out_cell_reg, out_cell_next;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [ADDR_W-1:0]  cursor_addr;
    logic [COL_W:0]     col_plus;
    logic [COL_W:0]     tab_col;
    logic               put_ok;
    logic               tab_ok;
    logic               row_last;
    logic               read_hit;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CELL_W-1:0]  rd_data;

    tmtw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign uc        = ucode_rom(pc_reg);
    assign s_tready  = (pc_reg == S_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = ~out_valid_reg | m_tready;
    assign out_load  = uc.emit & out_free;

    assign cursor_addr = ADDR_W'(row_reg) * COLUMNS_A + ADDR_W'(col_reg);
    assign col_plus    = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign tab_col     = ({1'b0, col_reg} + TAB_STEP) & ~TAB_MASK;
    assign put_ok      = (col_plus < COL_LIMIT);
    assign tab_ok      = (tab_col < COL_LIMIT);
    assign row_last    = (row_reg == ROW_LAST);
    assign read_hit    = (index_reg < CELLS_A);
    assign pc_inc      = step_t'(pc_reg + STEP_W'(1));

    // Sequencer: next step from the condition of the current control word.
    always_comb
    begin
        case (uc.cond)
            C_NEXT:      pc_next = pc_inc;
            C_GOTO:      pc_next = uc.target;
            C_ACCEPT:    pc_next = accept ? dispatch(s_tuser, s_tdata[CHAR_W-1:0]) : pc_reg;
            C_PUT_OK:    pc_next = put_ok ? uc.target : pc_inc;
            C_ROW_LAST:  pc_next = row_last ? uc.target : pc_inc;
            C_TAB_OK:    pc_next = tab_ok ? uc.target : pc_inc;
            C_COPY_LOOP: pc_next = (addr_reg == COPY_LAST) ? pc_inc : pc_reg;
            C_FILL_LOOP: pc_next = (addr_reg == FILL_LAST) ? pc_inc : pc_reg;
            C_EMIT:      pc_next = out_free ? uc.target : pc_reg;
            default:     pc_next = S_IDLE;
        endcase
    end

    // Datapath controlled by the current control word.
    always_comb
    begin
        kind_next      = kind_reg;
        char_next      = char_reg;
        index_next     = index_reg;
        color_next     = color_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        addr_next      = addr_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_cell_next  = out_cell_reg;
        out_valid_next = out_valid_reg & ~m_tready;

        if (accept) begin
            kind_next  = s_tuser;
            char_next  = s_tdata[CHAR_W-1:0];
            index_next = s_tdata[CHAR_W +: ADDR_W];
        end

        if (cfg_valid) begin
            color_next = cfg_data;
        end

        case (uc.col_op)
            COL_ZERO: col_next = '0;
            COL_INC:  col_next = col_plus[COL_W-1:0];
            COL_DEC:  col_next = (col_reg != '0) ? col_reg - COL_W'(1) : col_reg;
            COL_TAB:  col_next = tab_col[COL_W-1:0];
            default:  col_next = col_reg;
        endcase

        case (uc.row_op)
            ROW_ZERO: row_next = '0;
            ROW_INC:  row_next = row_reg + ROW_W'(1);
            default:  row_next = row_reg;
        endcase

        case (uc.addr_op)
            ADDR_ZERO: addr_next = '0;
            ADDR_INC:  addr_next = addr_reg + ADDR_W'(1);
            default:   addr_next = addr_reg;
        endcase

        // A scroll reads one row ahead; the data lands in the next cycle and is
        // written back one row up through the pending copy.
        copy_wr_next   = (uc.mem_op == MEM_COPY);
        copy_addr_next = addr_reg;

        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = {color_reg, CH_SPACE};
        rd_en   = 1'b0;
        rd_addr = index_reg;

        if (copy_wr_reg) begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data;
        end else begin
            case (uc.mem_op)
                MEM_PUT:
                begin
                    wr_en   = 1'b1;
                    wr_addr = cursor_addr;
                    wr_data = {color_reg, char_reg};
                end
                MEM_BLANK:
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_reg;
                    wr_data = {color_reg, CH_SPACE};
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end

        case (uc.mem_op)
            MEM_READ:
            begin
                rd_en   = read_hit;
                rd_addr = index_reg;
            end
            MEM_COPY:
            begin
                rd_en   = 1'b1;
                rd_addr = addr_reg + COLUMNS_A;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
            out_row_next   = row_reg;
            out_col_next   = col_reg;
            out_cell_next  = ((kind_reg == KIND_READ) && read_hit) ? rd_data : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg        <= S_IDLE;
            color_reg     <= COLOR_LIGHT_GRAY;
            row_reg       <= '0;
            col_reg       <= '0;
            copy_wr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            color_reg     <= color_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            copy_wr_reg   <= copy_wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        char_reg      <= char_next;
        index_reg     <= index_next;
        addr_reg      <= addr_next;
        copy_addr_reg <= copy_addr_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_cell_reg  <= out_cell_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), out_cell_reg, out_col_reg, out_row_reg};

    // A pending scroll copy only exists right after a copy step.
    a_copy_window: assert property (@(posedge clk) disable iff (!rst_n)
        copy_wr_reg |-> (pc_reg == S_COPY) || (pc_reg == S_DRAIN))
        else $error("copy write outside the scroll copy window");

    // The scroll copy must never collide with a character or blank write.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        copy_wr_reg |-> (uc.mem_op != MEM_PUT) && (uc.mem_op != MEM_BLANK))
        else $error("two writers on the cell RAM");

    // A character is always stored inside the screen.
    a_put_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_PUT) |-> (cursor_addr < CELLS_A) && (col_reg < COL_W'(COLUMNS)))
        else $error("character write outside the screen");

    // Leaving the emit step always leaves a result in the output register.
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_EMIT) && (pc_next == S_IDLE) |=> out_valid_reg)
        else $error("emit step finished without a result");

    // The cursor row never leaves the screen.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_LAST)
        else $error("cursor row beyond the last row");

endmodule
